>>> hw/rtl/elhc_pkg.sv
`default_nettype none

package elhc_pkg;

    // default width of the frame byte counter
    localparam int COUNT_BITS_DEF = 14;
    // widest counter the design supports, used for the frame size in a record
    localparam int SIZE_W = 16;

    localparam int QUEUE_DEPTH = 2;

    localparam int HDR_MIN      = 14;
    localparam int MAX_TYPE_LEN = 1500;
    localparam int PLEN_MAX     = 16383;
    localparam int PLEN_W       = 14;
    localparam int OFF_W        = 5;

    localparam logic [7:0]  SAP_SNAP  = 8'haa;
    localparam logic [7:0]  SAP_IPX   = 8'hff;
    localparam logic [7:0]  SAP_NETBIOS_IPX = 8'he0;
    localparam logic [15:0] IPX_PROTO = 16'h8137;

    localparam logic [OFF_W-1:0] OFF_ETH  = 5'd14;
    localparam logic [OFF_W-1:0] OFF_LLC  = 5'd17;
    localparam logic [OFF_W-1:0] OFF_SNAP = 5'd22;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_BAD_LEN = 2'd2,
        ST_TRUNC   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_ETH2 = 2'd0,
        KIND_SNAP = 2'd1,
        KIND_IPX  = 2'd2,
        KIND_LLC  = 2'd3
    } kind_t;

    // header fields of one complete frame, handed from front to back
    typedef struct packed {
        logic [SIZE_W-1:0] frame_size;
        logic [47:0]       dest_addr;
        logic [47:0]       source_addr;
        logic [15:0]       length_type;
        logic [7:0]        dsap;
        logic [7:0]        ssap;
        logic [15:0]       snap_type;
    } hdr_t;

endpackage

`default_nettype wire

>>> hw/rtl/ethernet_link_header_classifier.sv
`default_nettype none

// Ethernet link header classifier. Frames enter one byte per word through
// push/full, the final byte flagged by last_byte, and each frame yields one
// verdict word on the pop/empty side: status, frame kind (Ethernet II, SNAP,
// raw IPX, 802.2 LLC), protocol id, payload offset and length, and both MAC
// addresses. The input side takes one byte every cycle while full is low;
// the capture logic handles a byte per clock with no per-frame gap. After
// the final byte is taken, the header record passes through a two-entry
// queue and then the classify stage writes the output register. full rises
// only when the queue holds two header records while the output register
// waits to be popped. Frames longer than 2^COUNT_BITS - 1 bytes saturate
// the byte count.
module ethernet_link_header_classifier
    import elhc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  frame_byte,
    input  wire logic        last_byte,
    input  wire logic        pop,
    output logic             empty,
    output logic [1:0]       status,
    output logic [1:0]       frame_kind,
    output logic [15:0]      protocol_id,
    output logic [4:0]       payload_offset,
    output logic [13:0]      payload_length,
    output logic [47:0]      dest_mac,
    output logic [47:0]      source_mac
);

    hdr_t front_hdr;
    hdr_t queue_hdr;
    logic front_push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    elhc_front #(
        .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .frame_byte(frame_byte),
        .last_byte (last_byte),
        .hdr       (front_hdr),
        .hdr_push  (front_push)
    );

    elhc_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (front_push),
        .wr_data(front_hdr),
        .q_full (q_full),
        .q_valid(q_valid),
        .rd_en  (q_pop),
        .rd_data(queue_hdr)
    );

    elhc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .hdr           (queue_hdr),
        .hdr_valid     (q_valid),
        .hdr_pop       (q_pop),
        .pop           (pop),
        .empty         (empty),
        .status        (status),
        .frame_kind    (frame_kind),
        .protocol_id   (protocol_id),
        .payload_offset(payload_offset),
        .payload_length(payload_length),
        .dest_mac      (dest_mac),
        .source_mac    (source_mac)
    );

endmodule

`default_nettype wire

>>> hw/rtl/elhc_front.sv
`default_nettype none

module elhc_front
    import elhc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] frame_byte,
    input  wire logic       last_byte,
    output hdr_t            hdr,
    output logic            hdr_push
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] byte_count_reg, byte_count_next;
    logic [47:0]           dest_reg, dest_next;
    logic [47:0]           source_reg, source_next;
    logic [15:0]           length_type_reg, length_type_next;
    logic [7:0]            dsap_reg, dsap_next;
    logic [7:0]            ssap_reg, ssap_next;
    logic [15:0]           snap_type_reg, snap_type_next;

    // fields with the current word merged in
    logic [COUNT_BITS-1:0] count_upd;
    logic [47:0]           dest_upd;
    logic [47:0]           source_upd;
    logic [15:0]           length_type_upd;
    logic [7:0]            dsap_upd;
    logic [7:0]            ssap_upd;
    logic [15:0]           snap_type_upd;
    logic                  counting;

    assign counting = byte_count_reg != COUNT_MAX;

    always_comb
    begin
        dest_upd        = dest_reg;
        source_upd      = source_reg;
        length_type_upd = length_type_reg;
        dsap_upd        = dsap_reg;
        ssap_upd        = ssap_reg;
        snap_type_upd   = snap_type_reg;
        count_upd       = byte_count_reg;
        if (counting)
        begin
            count_upd = byte_count_reg + COUNT_BITS'(1);
            for (int i = 0; i < 6; i++)
            begin
                if (byte_count_reg == COUNT_BITS'(i))
                    dest_upd[8*(5-i) +: 8] = frame_byte;
                if (byte_count_reg == COUNT_BITS'(i + 6))
                    source_upd[8*(5-i) +: 8] = frame_byte;
            end
            if (byte_count_reg == COUNT_BITS'(12))
                length_type_upd[15:8] = frame_byte;
            if (byte_count_reg == COUNT_BITS'(13))
                length_type_upd[7:0] = frame_byte;
            if (byte_count_reg == COUNT_BITS'(14))
                dsap_upd = frame_byte;
            if (byte_count_reg == COUNT_BITS'(15))
                ssap_upd = frame_byte;
            if (byte_count_reg == COUNT_BITS'(20))
                snap_type_upd[15:8] = frame_byte;
            if (byte_count_reg == COUNT_BITS'(21))
                snap_type_upd[7:0] = frame_byte;
        end
    end

    always_comb
    begin
        hdr.frame_size  = SIZE_W'(count_upd);
        hdr.dest_addr   = dest_upd;
        hdr.source_addr = source_upd;
        hdr.length_type = length_type_upd;
        hdr.dsap        = dsap_upd;
        hdr.ssap        = ssap_upd;
        hdr.snap_type   = snap_type_upd;
        hdr_push        = accept && last_byte;
    end

    always_comb
    begin
        byte_count_next  = byte_count_reg;
        dest_next        = dest_reg;
        source_next      = source_reg;
        length_type_next = length_type_reg;
        dsap_next        = dsap_reg;
        ssap_next        = ssap_reg;
        snap_type_next   = snap_type_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                // start the next frame from a clean header
                byte_count_next  = '0;
                dest_next        = '0;
                source_next      = '0;
                length_type_next = '0;
                dsap_next        = '0;
                ssap_next        = '0;
                snap_type_next   = '0;
            end
            else
            begin
                byte_count_next  = count_upd;
                dest_next        = dest_upd;
                source_next      = source_upd;
                length_type_next = length_type_upd;
                dsap_next        = dsap_upd;
                ssap_next        = ssap_upd;
                snap_type_next   = snap_type_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            dest_reg        <= '0;
            source_reg      <= '0;
            length_type_reg <= '0;
            dsap_reg        <= '0;
            ssap_reg        <= '0;
            snap_type_reg   <= '0;
        end
        else
        begin
            byte_count_reg  <= byte_count_next;
            dest_reg        <= dest_next;
            source_reg      <= source_next;
            length_type_reg <= length_type_next;
            dsap_reg        <= dsap_next;
            ssap_reg        <= ssap_next;
            snap_type_reg   <= snap_type_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/elhc_queue.sv
`default_nettype none

module elhc_queue
    import elhc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  hdr_t      wr_data,
    output logic      q_full,
    output logic      q_valid,
    input  wire logic rd_en,
    output hdr_t      rd_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    hdr_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = fill_reg == CNT_W'(QUEUE_DEPTH);
    assign q_valid = fill_reg != '0;
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && q_valid;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_wr && !do_rd)
            fill_next = fill_reg + CNT_W'(1);
        else if (do_rd && !do_wr)
            fill_next = fill_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/elhc_back.sv
`default_nettype none

module elhc_back
    import elhc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  hdr_t             hdr,
    input  wire logic        hdr_valid,
    output logic             hdr_pop,
    input  wire logic        pop,
    output logic             empty,
    output logic [1:0]       status,
    output logic [1:0]       frame_kind,
    output logic [15:0]      protocol_id,
    output logic [OFF_W-1:0] payload_offset,
    output logic [PLEN_W-1:0] payload_length,
    output logic [47:0]      dest_mac,
    output logic [47:0]      source_mac
);

    logic               out_valid_reg, out_valid_next;
    status_t            status_reg;
    kind_t              kind_reg;
    logic [15:0]        proto_reg;
    logic [OFF_W-1:0]   off_reg;
    logic [PLEN_W-1:0]  plen_reg;
    logic [47:0]        dest_reg;
    logic [47:0]        source_reg;

    status_t            st_c;
    kind_t              kind_c;
    logic [15:0]        proto_c;
    logic [OFF_W-1:0]   off_c;
    logic [PLEN_W-1:0]  plen_c;
    logic [SIZE_W:0]    size_x;
    logic [SIZE_W:0]    lt_x;
    logic [SIZE_W:0]    rem;
    logic               trunc;
    logic               load;

    assign size_x = {1'b0, hdr.frame_size};
    assign lt_x   = (SIZE_W + 1)'(hdr.length_type);
    assign rem    = size_x - (SIZE_W + 1)'(HDR_MIN);
    // every llc variant needs the full header plus the declared length
    assign trunc  = size_x < lt_x + (SIZE_W + 1)'(HDR_MIN);

    always_comb
    begin
        st_c    = ST_OK;
        kind_c  = KIND_ETH2;
        proto_c = '0;
        off_c   = '0;
        plen_c  = '0;
        if (size_x < (SIZE_W + 1)'(HDR_MIN))
        begin
            st_c = ST_SHORT;
        end
        else if (lt_x > (SIZE_W + 1)'(MAX_TYPE_LEN))
        begin
            proto_c = hdr.length_type;
            off_c   = OFF_ETH;
            plen_c  = (rem > (SIZE_W + 1)'(PLEN_MAX)) ? PLEN_W'(PLEN_MAX) : rem[PLEN_W-1:0];
        end
        else if (hdr.dsap == SAP_SNAP && hdr.ssap == SAP_SNAP)
        begin
            kind_c = KIND_SNAP;
            if (hdr.length_type < 16'd8)
                st_c = ST_BAD_LEN;
            else if (trunc)
                st_c = ST_TRUNC;
            else
            begin
                proto_c = hdr.snap_type;
                off_c   = OFF_SNAP;
                plen_c  = PLEN_W'(hdr.length_type - 16'd8);
            end
        end
        else if (hdr.dsap == SAP_IPX && hdr.ssap == SAP_IPX)
        begin
            kind_c = KIND_IPX;
            if (trunc)
                st_c = ST_TRUNC;
            else
            begin
                proto_c = IPX_PROTO;
                off_c   = OFF_ETH;
                plen_c  = hdr.length_type[PLEN_W-1:0];
            end
        end
        else
        begin
            kind_c = KIND_LLC;
            if (hdr.length_type < 16'd3)
                st_c = ST_BAD_LEN;
            else if (trunc)
                st_c = ST_TRUNC;
            else
            begin
                proto_c = (hdr.dsap == SAP_NETBIOS_IPX && hdr.ssap == SAP_NETBIOS_IPX)
                          ? IPX_PROTO : {8'd0, hdr.dsap};
                off_c   = OFF_LLC;
                plen_c  = PLEN_W'(hdr.length_type - 16'd3);
            end
        end
    end

    // output word register refills in the same cycle it is taken if a header record is waiting
    assign load    = hdr_valid && (!out_valid_reg || pop);
    assign hdr_pop = load;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= st_c;
            kind_reg   <= kind_c;
            proto_reg  <= proto_c;
            off_reg    <= off_c;
            plen_reg   <= plen_c;
            dest_reg   <= hdr.dest_addr;
            source_reg <= hdr.source_addr;
        end
    end

    assign empty          = !out_valid_reg;
    assign status         = status_reg;
    assign frame_kind     = kind_reg;
    assign protocol_id    = proto_reg;
    assign payload_offset = off_reg;
    assign payload_length = plen_reg;
    assign dest_mac       = dest_reg;
    assign source_mac     = source_reg;

endmodule

`default_nettype wire
